// ===== hw/rtl/wgm_pkg.sv =====
// shared types and constants for the wildcard glob matcher
package wgm_pkg;

    // default number of pattern cells
    localparam int WGM_DEPTH = 64;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } wgm_cmd_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic clear;      // pattern cleared
        logic append;     // pattern byte appended
        logic text_step;  // one text byte consumed
        logic restart;    // state reloaded from the start closure
    } wgm_ctrl_t;

endpackage

// ===== hw/rtl/wgm_cell.sv =====
// one pattern position of the matcher: stored byte, start closure bit, nfa state bit
module wgm_cell
    import wgm_pkg::*;
#(
    parameter int PATTERN_DEPTH = WGM_DEPTH,
    parameter int CELL_INDEX    = 0,
    localparam int LEN_W        = $clog2(PATTERN_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wgm_ctrl_t        ctrl,
    input  logic [7:0]       char_byte,
    input  logic [LEN_W-1:0] pattern_length,
    input  logic             state_in,   // nfa state of the previous position
    input  logic             close_in,   // star closure carried from the left
    input  logic             init_in,    // start closure bit of the left neighbor
    output logic             act,        // this cell's nfa state
    output logic             close_out,
    output logic             init_out
);

    logic [7:0] pat_reg;
    logic       init_reg;
    logic       init_next;
    logic       act_reg;
    logic       act_next;
    logic       wr;
    logic       enabled;
    logic       star;
    logic       hit;
    logic       step_bit;

    assign wr      = ctrl.append && (pattern_length == LEN_W'(CELL_INDEX));
    assign enabled = LEN_W'(CELL_INDEX) < pattern_length;
    assign star    = (pat_reg == STAR_BYTE);
    assign hit     = (pat_reg == char_byte) || (pat_reg == ANY_BYTE);

    // consume one byte, then carry the star closure to the right
    assign step_bit  = enabled && (star ? (state_in || act_reg) : (hit && state_in));
    assign close_out = step_bit || (enabled && star && close_in);

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            init_next = 1'b0;
        end
        else if (wr)
        begin
            init_next = (char_byte == STAR_BYTE) && init_in;
        end
        else
        begin
            init_next = init_reg;
        end
    end

    always_comb
    begin
        priority if (ctrl.text_step)
        begin
            act_next = close_out;
        end
        else if (ctrl.restart)
        begin
            act_next = init_next;
        end
        else
        begin
            act_next = act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            pat_reg <= char_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b0;
            act_reg  <= 1'b0;
        end
        else
        begin
            init_reg <= init_next;
            act_reg  <= act_next;
        end
    end

    assign act      = act_reg;
    assign init_out = init_reg;

endmodule

// ===== hw/rtl/wildcard_glob_matcher_unit.sv =====
// top level of the wildcard glob matcher: handshakes, length, overflow and the cell row
//
// Wildcard glob matcher. The pattern is loaded one byte per item (command 1)
// after a clear (command 0); '*' matches any run of bytes including none, '?'
// matches exactly one byte, every other byte only itself. Text bytes (command
// 2) then stream through a row of PATTERN_DEPTH cells, one cell per pattern
// position, each holding its pattern byte and one bit of the NFA state; an
// end-of-text item (command 3) returns one result item with the verdict and the
// overflow flag, and the next text byte starts a fresh text against the same
// pattern. Appending a byte abandons any text in progress. Bytes beyond
// PATTERN_DEPTH are dropped and force a no-match verdict until the next clear.
// A new item is taken every cycle, limited only by the result register, which
// holds one verdict until the consumer takes it.
// The critical path is the star-closure ripple across the cell row, which has
// the shape of a PATTERN_DEPTH-bit carry chain.
module wildcard_glob_matcher_unit
    import wgm_pkg::*;
#(
    parameter int PATTERN_DEPTH = WGM_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);

    localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);

    wgm_cmd_t                 cmd;
    logic                     in_fire;
    wgm_ctrl_t                ctrl;

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic                     s0_reg;     // nfa state 0: no text byte taken yet
    logic                     s0_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     matched_reg;
    logic                     matched_next;
    logic                     ovf_out_reg;
    logic                     ovf_out_next;

    // chains between neighboring cells
    logic [PATTERN_DEPTH-1:0] act_vec;
    logic [PATTERN_DEPTH:0]   state_chain;
    logic [PATTERN_DEPTH-1:0] close_chain;
    logic [PATTERN_DEPTH-1:0] init_chain;
    logic                     accept_bit;

    assign cmd      = wgm_cmd_t'(command);
    // an item may enter whenever the result slot is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign ctrl.clear     = in_fire && (cmd == CMD_CLEAR);
    assign ctrl.append    = in_fire && (cmd == CMD_APPEND) &&
                            (len_reg != LEN_W'(PATTERN_DEPTH));
    assign ctrl.text_step = in_fire && (cmd == CMD_TEXT);
    // clear, append and end of text all send the row back to the start closure
    assign ctrl.restart   = in_fire && (cmd != CMD_TEXT);

    // state k of the nfa sits at bit k; state 0 lives here in the top level
    assign state_chain    = {act_vec, s0_reg};
    assign close_chain[0] = 1'b0;
    assign init_chain[0]  = 1'b1;

    genvar k;
    generate
        for (k = 0; k < PATTERN_DEPTH; k++)
        begin : g_cell
            if (k < PATTERN_DEPTH - 1)
            begin : g_mid
                wgm_cell #(
                    .PATTERN_DEPTH (PATTERN_DEPTH),
                    .CELL_INDEX    (k)
                ) u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .ctrl           (ctrl),
                    .char_byte      (char_byte),
                    .pattern_length (len_reg),
                    .state_in       (state_chain[k]),
                    .close_in       (close_chain[k]),
                    .init_in        (init_chain[k]),
                    .act            (act_vec[k]),
                    .close_out      (close_chain[k+1]),
                    .init_out       (init_chain[k+1])
                );
            end
            else
            begin : g_last
                // last cell: nothing to its right
                wgm_cell #(
                    .PATTERN_DEPTH (PATTERN_DEPTH),
                    .CELL_INDEX    (k)
                ) u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .ctrl           (ctrl),
                    .char_byte      (char_byte),
                    .pattern_length (len_reg),
                    .state_in       (state_chain[k]),
                    .close_in       (close_chain[k]),
                    .init_in        (init_chain[k]),
                    .act            (act_vec[k]),
                    .close_out      (),
                    .init_out       ()
                );
            end
        end
    endgenerate

    // whole pattern consumed exactly when the state at the pattern length is on
    assign accept_bit = state_chain[len_reg];

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        s0_next        = s0_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        ovf_out_next   = ovf_out_reg;
        if (in_fire)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    s0_next  = 1'b1;
                end
                CMD_APPEND:
                begin
                    if (len_reg == LEN_W'(PATTERN_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    s0_next = 1'b1;
                end
                CMD_TEXT:
                begin
                    s0_next = 1'b0;
                end
                CMD_END:
                begin
                    s0_next        = 1'b1;
                    out_valid_next = 1'b1;
                    matched_next   = accept_bit && !ovf_reg;
                    ovf_out_next   = ovf_reg;
                end
                default:
                begin
                    s0_next = s0_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            s0_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            s0_reg        <= s0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with each verdict
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

    // a clear empties the pattern and drops the overflow flag
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (len_reg == '0) && !ovf_reg)
        else $error("pattern not empty after clear");

    // the length never runs past the cell row
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PATTERN_DEPTH))
        else $error("pattern length beyond depth");

    // a verdict with overflow is never a match
    a_no_match_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_out_reg |-> !matched_reg)
        else $error("match reported with overflow");

    // a result appears only after an end of text item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && (cmd == CMD_END)))
        else $error("result without end of text");

    // a text byte leaves the start state
    a_text_leaves_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.text_step |=> !s0_reg)
        else $error("start state still on after text byte");

endmodule

// ===== dv/tb_wildcard_glob_matcher_unit.sv =====
// self-checking testbench for the wildcard glob matcher unit
module tb_wildcard_glob_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wgm_pkg::*;

    // run length and pressure points; burst windows and the hold-off start are counted in offered items
    localparam int STIM_ITEMS    = 825;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 11;
    localparam int TX_BURST_LO   = 350;  // sender never idles inside this window
    localparam int TX_BURST_HI   = 480;
    localparam int RX_BURST_LO   = 150;  // receiver never idles inside this window
    localparam int RX_BURST_HI   = 300;
    localparam int RX_HOLD_AT    = 600;  // receiver holds off once from here
    localparam int RX_HOLD_LEN   = 400;
    localparam int TAIL_CYCLES   = 20;

    // one item on the input channel; a drain entry makes the sender wait for all verdicts
    typedef struct {
        wgm_cmd_t   cmd;
        logic [7:0] ch;
        bit         drain;
    } glob_item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] command = CMD_CLEAR;
    logic [7:0] char_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       matched;
    logic       pattern_overflow;

    glob_item_t pending_items[$];
    verdict_t   verdict_q[$];

    int stim_count    = 0;
    int offered_count = 0;
    int taken_count   = 0;
    int results_seen  = 0;
    int match_count   = 0;
    int ovf_count     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // predictor state: pattern cells, length, nfa vector (bit k is state k), flags
    logic [7:0]         pat_mem [WGM_DEPTH];
    int                 pat_len = 0;
    logic [WGM_DEPTH:0] live = '0;
    bit                 text_on = 1'b0;
    bit                 ovf = 1'b0;

    wildcard_glob_matcher_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .char_byte        (char_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // epsilon moves: an active state in front of a star also enables the state after it
    function automatic logic [WGM_DEPTH:0] star_closure(input logic [WGM_DEPTH:0] v);
        for (int k = 0; k < WGM_DEPTH; k++)
        begin
            if (k < pat_len && pat_mem[k] == STAR_BYTE && v[k])
                v[k+1] = 1'b1;
        end
        return v;
    endfunction

    task automatic predict_glob(input wgm_cmd_t cmd, input logic [7:0] ch);
        logic [WGM_DEPTH:0] cur;
        logic [WGM_DEPTH:0] nxt;
        verdict_t           v;
        // a fresh text starts from state 0 and its star closure
        cur = text_on ? live : star_closure({{WGM_DEPTH{1'b0}}, 1'b1});
        case (cmd)
            CMD_CLEAR:
            begin
                pat_len = 0;
                ovf     = 1'b0;
                live    = '0;
                text_on = 1'b0;
            end
            CMD_APPEND:
            begin
                if (pat_len < WGM_DEPTH)
                begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end
                else
                begin
                    ovf = 1'b1;
                end
                // any text in progress is dropped
                live    = '0;
                text_on = 1'b0;
            end
            CMD_TEXT:
            begin
                nxt = '0;
                for (int k = 0; k < WGM_DEPTH; k++)
                begin
                    if (k < pat_len)
                    begin
                        if (pat_mem[k] == STAR_BYTE)
                        begin
                            // star entered from state k or kept at state k+1
                            if (cur[k] || cur[k+1])
                                nxt[k+1] = 1'b1;
                        end
                        else if ((pat_mem[k] == ch || pat_mem[k] == ANY_BYTE) && cur[k])
                        begin
                            nxt[k+1] = 1'b1;
                        end
                    end
                end
                live    = star_closure(nxt);
                text_on = 1'b1;
            end
            default:
            begin
                v.matched  = cur[pat_len] && !ovf;
                v.overflow = ovf;
                verdict_q.push_back(v);
                live    = '0;
                text_on = 1'b0;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic add_item(input wgm_cmd_t c, input logic [7:0] b);
        glob_item_t it;
        it.cmd   = c;
        it.ch    = b;
        it.drain = 1'b0;
        pending_items.push_back(it);
        stim_count++;
    endtask

    // mostly a tiny alphabet so that literals line up, sometimes any byte
    function automatic logic [7:0] alpha_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'("a") + 8'($urandom_range(0, 2));
    endfunction

    // one session: optional clear, a pattern, then a few texts each closed by end of text
    task automatic build_session(input bit force_long);
        logic [7:0] pat_q[$];
        logic [7:0] txt_q[$];
        logic [7:0] b;
        int         plen;
        int         ntext;
        int         r;
        int         idx;
        if (force_long || $urandom_range(0, 9) != 0)
            add_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
        if (force_long)
            plen = 66;
        else if ($urandom_range(0, 29) == 0)
            plen = $urandom_range(60, 68);
        else
            plen = $urandom_range(0, 8);
        for (int i = 0; i < plen; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
                b = STAR_BYTE;
            else if (r < 38)
                b = ANY_BYTE;
            else if (r < 90)
                b = alpha_byte();
            else
                b = 8'($urandom_range(0, 255));
            add_item(CMD_APPEND, b);
            pat_q.push_back(b);
        end
        ntext = $urandom_range(1, 4);
        for (int t = 0; t < ntext; t++)
        begin
            txt_q.delete();
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                // unrelated text
                repeat ($urandom_range(0, 6)) txt_q.push_back(alpha_byte());
            end
            else
            begin
                // text built to fit the pattern
                foreach (pat_q[i])
                begin
                    if (pat_q[i] == STAR_BYTE)
                        repeat ($urandom_range(0, 3)) txt_q.push_back(alpha_byte());
                    else if (pat_q[i] == ANY_BYTE)
                        txt_q.push_back(8'($urandom_range(0, 255)));
                    else
                        txt_q.push_back(pat_q[i]);
                end
                // some fitted texts are spoiled: one byte flipped or one extra byte
                if (r >= 85)
                begin
                    if (txt_q.size() != 0 && r < 93)
                    begin
                        idx = $urandom_range(0, txt_q.size() - 1);
                        txt_q[idx] = txt_q[idx] ^ 8'($urandom_range(1, 255));
                    end
                    else
                    begin
                        txt_q.push_back(alpha_byte());
                    end
                end
            end
            foreach (txt_q[i])
                add_item(CMD_TEXT, txt_q[i]);
            // noise: pattern grows or is wiped while a text runs
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                b = alpha_byte();
                add_item(CMD_APPEND, b);
                pat_q.push_back(b);
            end
            else if (r < 8)
            begin
                add_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
                pat_q.delete();
            end
            add_item(CMD_END, 8'($urandom_range(0, 255)));
            // back to back verdicts, second one on an empty text
            if ($urandom_range(0, 24) == 0)
                add_item(CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // sender: presents items at the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drive_proc
        glob_item_t nxt_item;
        bit         go;
        if (rst_n)
        begin
            // hold the current item until it is taken
            if (!(in_valid && taken_count != offered_count))
            begin
                // drain point: wait until every verdict has been delivered
                if (pending_items.size() != 0 && pending_items[0].drain
                    && verdict_q.size() == 0 && !out_valid)
                    void'(pending_items.pop_front());
                go = pending_items.size() != 0 && !pending_items[0].drain
                     && ((offered_count >= TX_BURST_LO && offered_count < TX_BURST_HI)
                         || $urandom_range(0, 99) >= IDLE_PCT);
                if (go)
                begin
                    nxt_item  = pending_items.pop_front();
                    command   <= nxt_item.cmd;
                    char_byte <= nxt_item.ch;
                    in_valid  <= 1'b1;
                    offered_count++;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : receive_proc
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        if (rst_n)
        begin
            if (!hold_done && offered_count >= RX_HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_LEN;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (offered_count >= RX_BURST_LO && offered_count < RX_BURST_HI)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks delivered verdicts first, then feeds accepted items to the predictor
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : observe_proc
        verdict_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (matched === 1'b1)
                    match_count++;
                if (pattern_overflow === 1'b1)
                    ovf_count++;
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected verdict: matched %0b pattern_overflow %0b",
                           matched, pattern_overflow);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (matched !== want.matched)
                    begin
                        $error("matched: expected %0b, got %0b", want.matched, matched);
                        fail_count++;
                    end
                    if (pattern_overflow !== want.overflow)
                    begin
                        $error("pattern_overflow: expected %0b, got %0b",
                               want.overflow, pattern_overflow);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                taken_count++;
                predict_glob(wgm_cmd_t'(command), char_byte);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : main_proc
        glob_item_t marker;

        // directed part
        add_item(CMD_END, 8'h00);             // empty pattern, empty text
        add_item(CMD_TEXT, "a");              // empty pattern vs one byte
        add_item(CMD_END, 8'hFF);
        add_item(CMD_APPEND, STAR_BYTE);      // star-only pattern, empty text
        add_item(CMD_END, 8'h00);
        add_item(CMD_APPEND, 8'h00);          // pattern: star, 0x00, any, 0xff
        add_item(CMD_APPEND, ANY_BYTE);
        add_item(CMD_APPEND, 8'hFF);
        add_item(CMD_TEXT, "x");
        add_item(CMD_TEXT, 8'h00);
        add_item(CMD_TEXT, 8'h55);
        add_item(CMD_TEXT, 8'hFF);
        add_item(CMD_END, 8'h00);
        add_item(CMD_TEXT, 8'h00);            // append while a text runs drops it
        add_item(CMD_APPEND, STAR_BYTE);
        add_item(CMD_TEXT, 8'h00);
        add_item(CMD_TEXT, 8'h01);
        add_item(CMD_TEXT, 8'hFF);
        add_item(CMD_END, 8'hFF);
        add_item(CMD_TEXT, 8'hFF);            // new text after a verdict, same pattern
        add_item(CMD_END, 8'h00);
        add_item(CMD_CLEAR, 8'hFF);           // single any vs empty text
        add_item(CMD_APPEND, ANY_BYTE);
        add_item(CMD_END, 8'h00);

        // sender pause until all verdicts are home
        marker.cmd   = CMD_CLEAR;
        marker.ch    = 8'h00;
        marker.drain = 1'b1;
        pending_items.push_back(marker);

        // random part, opening with one pattern past capacity
        build_session(1'b1);
        while (stim_count < STIM_ITEMS)
            build_session(1'b0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("items accepted: %0d, verdicts checked: %0d", taken_count, results_seen);
        $display("verdicts with match: %0d, with pattern overflow: %0d",
                 match_count, ovf_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
